// File: hdl/nre_pkg.sv
// Package for the nuclear repulsion energy block: fixed widths, the stored
// atom word, and the sequencer state type. No dependencies.
package nre_pkg;

    localparam int COORD_W    = 32;
    localparam int CHARGE_W   = 7;
    localparam int ZZ_W       = 2 * CHARGE_W;
    localparam int SQ_W       = 66;
    localparam int ROOT_W     = 34;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SQRT_CNT_W = 6;
    localparam int ENERGY_W   = 63;
    localparam int ENERGY_FRAC_BITS = 24;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [CHARGE_W-1:0] charge;
    } atom_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LOAD_A,
        ST_A_CAP,
        ST_LOAD_B,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_SUM,
        ST_CHECK,
        ST_SQRT,
        ST_DIV,
        ST_ACC,
        ST_NEXT,
        ST_FINISH
    } state_t;

endpackage

// File: hdl/nuclear_repulsion_energy.sv
// Top level: atom loading, pair sequencer, shared squarer, accumulator.
// Depends on nre_pkg, nre_store, nre_isqrt and nre_div.
//
//  channel | ports                                        | direction
//  s_      | pos_x, pos_y, pos_z, charge, last_atom       | atom words in
//  m_      | energy, atom_count, zero_distance, overflowed | one result word per set
//
// A word marked last starts the pair sum, during which s_ready is low. Each pair
// is fetched and squared, then goes through the square root and the divide; a new
// first atom is fetched through an extra state. Coincident pairs skip the root and
// divide.
// Reset clears the atom count and flags; the store is not cleared.
// A finished result waits in the output register while new atoms load.
module nuclear_repulsion_energy
    import nre_pkg::*;
#(
    parameter int MAX_ATOMS       = 64,
    parameter int COORD_FRAC_BITS = 16,
    localparam int AW = $clog2(MAX_ATOMS),
    localparam int CW = $clog2(MAX_ATOMS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [COORD_W-1:0]  s_pos_x,
    input  logic [COORD_W-1:0]  s_pos_y,
    input  logic [COORD_W-1:0]  s_pos_z,
    input  logic [CHARGE_W-1:0] s_charge,
    input  logic                s_last_atom,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ENERGY_W-1:0] m_energy,
    output logic [CW-1:0]       m_atom_count,
    output logic                m_zero_distance,
    output logic                m_overflowed
);

    localparam int SHIFT = ENERGY_FRAC_BITS + COORD_FRAC_BITS;
    localparam int NUM_W = ZZ_W + SHIFT;

    state_t state_reg, state_next;

    logic [CW-1:0]       count_reg, count_next;
    logic                drop_reg, drop_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    atom_t               a_reg;
    logic [2*COORD_W-1:0] mul_reg;
    logic [SQ_W-1:0]     s_reg;
    logic [ZZ_W-1:0]     zz_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic                zero_reg;
    logic                sat_reg;

    logic                m_valid_reg;
    logic [ENERGY_W-1:0] m_energy_reg;
    logic [CW-1:0]       m_count_reg;
    logic                m_zero_reg;
    logic                m_ovf_reg;

    logic                accept;
    logic                wr_en;
    atom_t               wr_data;
    logic                rd_en;
    logic [CW-1:0]       rd_idx;
    atom_t               b_atom;
    logic                sqrt_start;
    logic                div_start;
    logic                sqrt_done;
    logic                div_done;
    logic [ROOT_W-1:0]   root;
    logic [NUM_W-1:0]    term;
    logic [COORD_W-1:0]  coord_a;
    logic [COORD_W-1:0]  coord_b;
    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0]  mag;
    logic [ENERGY_W:0]   sum;

    assign accept  = s_valid && s_ready;
    assign wr_en   = accept && (count_reg < CW'(MAX_ATOMS));
    assign wr_data = '{x: s_pos_x, y: s_pos_y, z: s_pos_z, charge: s_charge};

    nre_store #(.DEPTH(MAX_ATOMS), .AW(AW)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (b_atom)
    );

    nre_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (s_reg),
        .root     (root),
        .done     (sqrt_done)
    );

    nre_div #(.NUM_W(NUM_W), .DEN_W(ROOT_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({zz_reg, {SHIFT{1'b0}}}),
        .divisor  (root),
        .quotient (term),
        .done     (div_done)
    );

    // Shared squarer: the coordinate pair is picked by the current state.
    always_comb begin
        case (state_reg)
            ST_SQ_Y: begin
                coord_a = a_reg.y;
                coord_b = b_atom.y;
            end
            ST_SQ_Z: begin
                coord_a = a_reg.z;
                coord_b = b_atom.z;
            end
            default: begin
                coord_a = a_reg.x;
                coord_b = b_atom.x;
            end
        endcase
        diff = $signed({coord_a[COORD_W-1], coord_a}) - $signed({coord_b[COORD_W-1], coord_b});
        mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
    end

    assign sum = {1'b0, energy_reg} + (ENERGY_W+1)'(term);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept && s_last_atom) state_next = ST_START;
            ST_START:  state_next = (count_reg < CW'(2)) ? ST_FINISH : ST_LOAD_A;
            ST_LOAD_A: state_next = ST_A_CAP;
            ST_A_CAP:  state_next = ST_SQ_X;
            ST_LOAD_B: state_next = ST_SQ_X;
            ST_SQ_X:   state_next = ST_SQ_Y;
            ST_SQ_Y:   state_next = ST_SQ_Z;
            ST_SQ_Z:   state_next = ST_SQ_SUM;
            ST_SQ_SUM: state_next = ST_CHECK;
            ST_CHECK:  state_next = (s_reg == '0) ? ST_NEXT : ST_SQRT;
            ST_SQRT:   if (sqrt_done) state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_ACC;
            ST_ACC:    state_next = ST_NEXT;
            ST_NEXT: begin
                if (j_reg + 1'b1 < count_reg) begin
                    state_next = ST_LOAD_B;
                end else if (CW'(i_reg + 2'd2) < count_reg) begin
                    state_next = ST_LOAD_A;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: if (!m_valid_reg) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready    = 1'b0;
        rd_en      = 1'b0;
        rd_idx     = j_reg;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_LOAD_A: begin
                rd_en  = 1'b1;
                rd_idx = i_reg;
            end
            ST_A_CAP:  rd_en = 1'b1;
            ST_LOAD_B: rd_en = 1'b1;
            ST_CHECK:  sqrt_start = (s_reg != '0);
            ST_SQRT:   div_start = sqrt_done;
            default:   ;
        endcase
    end

    // Load counter and drop flag.
    always_comb begin
        count_next = count_reg;
        drop_next  = drop_reg;
        if (wr_en) begin
            count_next = count_reg + 1'b1;
        end else if (accept) begin
            drop_next = 1'b1;
        end
        if (state_reg == ST_FINISH && !m_valid_reg) begin
            count_next = '0;
            drop_next  = 1'b0;
        end
    end

    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        case (state_reg)
            ST_START: begin
                i_next = '0;
                j_next = CW'(1);
            end
            ST_NEXT: begin
                if (j_reg + 1'b1 < count_reg) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    i_next = i_reg + 1'b1;
                    j_next = CW'(i_reg + 2'd2);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            if (state_reg == ST_FINISH && !m_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        i_reg <= i_next;
        j_reg <= j_next;
        case (state_reg)
            ST_START: begin
                energy_reg <= '0;
                zero_reg   <= 1'b0;
                sat_reg    <= 1'b0;
            end
            ST_A_CAP: a_reg <= b_atom;
            ST_SQ_X:  mul_reg <= mag * mag;
            ST_SQ_Y: begin
                s_reg   <= SQ_W'(mul_reg);
                mul_reg <= mag * mag;
            end
            ST_SQ_Z: begin
                s_reg   <= s_reg + SQ_W'(mul_reg);
                mul_reg <= mag * mag;
            end
            ST_SQ_SUM: begin
                s_reg  <= s_reg + SQ_W'(mul_reg);
                zz_reg <= a_reg.charge * b_atom.charge;
            end
            ST_CHECK: if (s_reg == '0) zero_reg <= 1'b1;
            ST_ACC: begin
                if (sum > {1'b0, ENERGY_MAX}) begin
                    energy_reg <= ENERGY_MAX;
                    sat_reg    <= 1'b1;
                end else begin
                    energy_reg <= sum[ENERGY_W-1:0];
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg) begin
                    m_energy_reg <= (count_reg < CW'(2)) ? '0 : energy_reg;
                    m_count_reg  <= count_reg;
                    m_zero_reg   <= (count_reg < CW'(2)) ? 1'b0 : zero_reg;
                    m_ovf_reg    <= drop_reg || ((count_reg >= CW'(2)) && sat_reg);
                end
            end
            default: ;
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_energy        = m_energy_reg;
    assign m_atom_count    = m_count_reg;
    assign m_zero_distance = m_zero_reg;
    assign m_overflowed    = m_ovf_reg;

endmodule

// File: hdl/nre_store.sv
// Atom store: one write port and one registered read port.
// Depends on nre_pkg for the atom word type.
module nre_store
    import nre_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  atom_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output atom_t         rd_data
);

    atom_t mem [DEPTH];
    atom_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/nre_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on nre_pkg for widths.
module nre_isqrt
    import nre_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic [ROOT_W-1:0] root,
    output logic              done
);

    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;
    logic                  ge;

    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = {{(RAD_W-SQ_W){1'b0}}, radicand};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// File: hdl/nre_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nre_pkg only through the shared import convention.
module nre_div
    import nre_pkg::*;
#(
    parameter int NUM_W = 54,
    parameter int DEN_W = 34
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg, q_reg[NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
            q_next   = {q_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// File: hdl/nre_checker.sv
// Port-level checks for the nuclear repulsion energy block, bound to the top.
// Depends on nre_pkg for widths.
module nre_checker
    import nre_pkg::*;
#(
    parameter int MAX_ATOMS = 64,
    localparam int CW = $clog2(MAX_ATOMS + 1)
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_last_atom,
    input logic                m_valid,
    input logic                m_ready,
    input logic [ENERGY_W-1:0] m_energy,
    input logic [CW-1:0]       m_atom_count
);

    // A last word starts the pair sum, so no load is taken right after it.
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_atom |=> !s_ready)
        else $error("input taken right after a last word");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_atom_count <= CW'(MAX_ATOMS))
        else $error("atom count above store size");

    // With fewer than two atoms there is no pair to sum.
    a_small_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_atom_count < CW'(2)) |-> m_energy == '0)
        else $error("nonzero energy for fewer than two atoms");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_energy))
        else $error("result word changed while stalled");

endmodule

bind nuclear_repulsion_energy nre_checker #(.MAX_ATOMS(MAX_ATOMS)) u_nre_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_last_atom  (s_last_atom),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_energy     (m_energy),
    .m_atom_count (m_atom_count)
);

// File: tb/nre_energy_checker.sv
// Checker for nuclear_repulsion_energy: watches both channels, predicts the
// result word of each atom set and compares it. Depends on nre_pkg.
module nre_energy_checker
    import nre_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [COORD_W-1:0]  s_pos_x,
    input  logic [COORD_W-1:0]  s_pos_y,
    input  logic [COORD_W-1:0]  s_pos_z,
    input  logic [CHARGE_W-1:0] s_charge,
    input  logic                s_last_atom,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [ENERGY_W-1:0] m_energy,
    input  logic [6:0]          m_atom_count,
    input  logic                m_zero_distance,
    input  logic                m_overflowed,
    output int                  errors,
    output int                  pending,
    output int                  results_checked
);
    localparam int STORE_DEPTH = 64;
    localparam int FRAC_BITS   = 16;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [6:0]          atom_count;
        logic                zero_distance;
        logic                overflowed;
    } set_result_t;

    atom_t        atoms [STORE_DEPTH];
    int           atoms_held;
    logic         atom_dropped;
    set_result_t  expected_sets [$];

    function automatic logic [67:0] dist_sq(atom_t a, atom_t b);
        logic signed [32:0] dx, dy, dz;
        logic [32:0]        mx, my, mz;
        dx = $signed({a.x[31], a.x}) - $signed({b.x[31], b.x});
        dy = $signed({a.y[31], a.y}) - $signed({b.y[31], b.y});
        dz = $signed({a.z[31], a.z}) - $signed({b.z[31], b.z});
        mx = dx[32] ? -dx : dx;
        my = dy[32] ? -dy : dy;
        mz = dz[32] ? -dz : dz;
        return 68'(mx) * 68'(mx) + 68'(my) * 68'(my) + 68'(mz) * 68'(mz);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [67:0] s);
        logic [33:0] root;
        logic [33:0] trial;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            trial = root | (34'd1 << b);
            if (68'(trial) * 68'(trial) <= s)
                root = trial;
        end
        return 64'(root);
    endfunction

    function automatic set_result_t pair_energy();
        set_result_t res;
        logic [67:0] s;
        logic [63:0] r, num, term, acc;
        logic        sat;
        acc = '0;
        sat = 1'b0;
        res = '0;
        for (int i = 0; i < atoms_held; i++) begin
            for (int j = i + 1; j < atoms_held; j++) begin
                s = dist_sq(atoms[i], atoms[j]);
                if (s == 0) begin
                    res.zero_distance = 1'b1;
                end else begin
                    r = int_sqrt(s);
                    if (r == 0)
                        r = 1;
                    num = (64'(atoms[i].charge) * 64'(atoms[j].charge))
                          << (ENERGY_FRAC_BITS + FRAC_BITS);
                    term = num / r;
                    if (term > 64'(ENERGY_MAX) - acc) begin
                        acc = 64'(ENERGY_MAX);
                        sat = 1'b1;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
        end
        res.energy     = acc[ENERGY_W-1:0];
        res.atom_count = 7'(atoms_held);
        res.overflowed = atom_dropped | sat;
        return res;
    endfunction

    assign pending = expected_sets.size();

    always @(posedge aclk) begin
        set_result_t want;
        if (!aresetn) begin
            atoms_held = 0;
            atom_dropped = 1'b0;
            expected_sets.delete();
            errors = 0;
            results_checked = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (atoms_held < STORE_DEPTH) begin
                    atoms[atoms_held] = '{s_pos_x, s_pos_y, s_pos_z, s_charge};
                    atoms_held++;
                end else begin
                    atom_dropped = 1'b1;
                end
                if (s_last_atom) begin
                    expected_sets = {expected_sets, pair_energy()};
                    atoms_held = 0;
                    atom_dropped = 1'b0;
                end
            end
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_sets.size() == 0) begin
                    $error("result word with no atom set pending");
                    errors++;
                end else begin
                    want = expected_sets.pop_front();
                    if (m_energy !== want.energy) begin
                        $error("energy: expected %0d, got %0d", want.energy, m_energy);
                        errors++;
                    end
                    if (m_atom_count !== want.atom_count) begin
                        $error("atom_count: expected %0d, got %0d",
                               want.atom_count, m_atom_count);
                        errors++;
                    end
                    if (m_zero_distance !== want.zero_distance) begin
                        $error("zero_distance: expected %0d, got %0d",
                               want.zero_distance, m_zero_distance);
                        errors++;
                    end
                    if (m_overflowed !== want.overflowed) begin
                        $error("overflowed: expected %0d, got %0d",
                               want.overflowed, m_overflowed);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

// File: tb/tb_nuclear_repulsion_energy.sv
// Testbench top for nuclear_repulsion_energy: clock, reset, atom stimulus,
// receiver stalls and verdict. Depends on nre_pkg and nre_energy_checker.
module tb_nuclear_repulsion_energy;
    import nre_pkg::*;

    localparam int STALL_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 4000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [COORD_W-1:0]  s_pos_x, s_pos_y, s_pos_z;
    logic [CHARGE_W-1:0] s_charge;
    logic                s_last_atom;
    logic                m_valid;
    logic                m_ready;
    logic [ENERGY_W-1:0] m_energy;
    logic [6:0]          m_atom_count;
    logic                m_zero_distance;
    logic                m_overflowed;

    int errors, pending, results_checked;
    int sender_idle_pct, receiver_idle_pct;
    int atoms_sent, sets_sent, quiet_cycles;
    bit hold_receiver;

    nuclear_repulsion_energy dut (.*);

    nre_energy_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_receiver) begin
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge aclk);
            hold_receiver = 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Watchdog on cycles with no word moving on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_nuclear_repulsion_energy: done, errors");
            $finish;
        end
    end

    task automatic send_atom(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [6:0] q, logic last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_pos_x     <= x;
        s_pos_y     <= y;
        s_pos_z     <= z;
        s_charge    <= q;
        s_last_atom <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        atoms_sent++;
        if (last)
            sets_sent++;
    endtask

    // Coordinate styles: full range, a tiny grid (coincident atoms likely),
    // or a moderate spread around the origin.
    function automatic logic [31:0] rand_coord(int style);
        case (style)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 3)) - 2);
            default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    task automatic random_set();
        int n, style;
        logic [6:0] q;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
        style = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) begin
            q = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 118));
            send_atom(rand_coord(style), rand_coord(style), rand_coord(style),
                      q, k == n - 1);
        end
    endtask

    // The sender goes quiet first so the last word is not taken again.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    initial begin
        int phase_start;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_pos_z = '0;
        s_charge = '0;
        s_last_atom = 1'b0;
        m_ready = 1'b0;
        hold_receiver = 1'b0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        atoms_sent = 0;
        sets_sent = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: a lone atom, the coordinate extremes with extreme charges,
        // a coincident pair, and a zero charge.
        send_atom(32'h7fff_ffff, 32'h8000_0000, 32'h0, 7'd118, 1'b1);
        send_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 7'd127, 1'b0);
        send_atom(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 7'd127, 1'b1);
        send_atom(32'h0001_0000, 32'h0, 32'hffff_0000, 7'd1, 1'b0);
        send_atom(32'h0001_0000, 32'h0, 32'hffff_0000, 7'd8, 1'b0);
        send_atom(32'h0, 32'h0, 32'h0, 7'd0, 1'b0);
        send_atom(32'hffff_ffff, 32'h0000_0001, 32'h5555_aaaa, 7'd1, 1'b1);
        drain();

        // A full store plus two dropped atoms, packed tightly enough to saturate.
        for (int k = 0; k < 66; k++)
            send_atom(32'(k % 4), 32'((k / 4) % 4), 32'(k / 16), 7'd127, k == 65);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct   = (phase == 0) ? 32 : (phase == 1) ? 53 : 0;
            receiver_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 32 : 0;
            if (phase == 2)
                hold_receiver = 1'b1;
            phase_start = atoms_sent;
            while (atoms_sent - phase_start < 108)
                random_set();
        end
        drain();

        $display("Sent %0d atoms in %0d sets; %0d result words checked.",
                 atoms_sent, sets_sent, results_checked);
        if (errors == 0)
            $display("tb_nuclear_repulsion_energy: done, clean");
        else
            $display("tb_nuclear_repulsion_energy: done, errors");
        $finish;
    end
endmodule
